/* rtl/nau_pkg.sv */
// Shared types, codes and fixed-point constants of the neural activation unit.
// Depends on nothing; the top level, nau_front, nau_back and nau_exp import it.
package nau_pkg;

	// Fixed-point format of samples and results
	localparam int FRAC_BITS = 12;
	localparam int Q_SHIFT   = 30 - FRAC_BITS;
	localparam logic signed [15:0] FX_ONE = 16'sd1 <<< FRAC_BITS;

	// Row length field of a command, wide enough for the largest row store
	localparam int CNT_W = 7;

	// Q30 constants of the exponential unit
	localparam logic [31:0] Q30_ONE   = 32'h4000_0000;
	localparam logic [29:0] LN2_Q30   = 30'd744261118;
	localparam logic [63:0] LN2_RECIP = (64'd1 << 50) / 64'd744261118;

	// Activation kinds in the kind register
	localparam logic [2:0] KIND_RELU    = 3'd0;
	localparam logic [2:0] KIND_SIGMOID = 3'd1;
	localparam logic [2:0] KIND_TANH    = 3'd2;
	localparam logic [2:0] KIND_LINEAR  = 3'd3;
	localparam logic [2:0] KIND_SOFTMAX = 3'd4;

	// Configuration register indexes
	localparam logic CFG_KIND = 1'b0;
	localparam logic CFG_DIR  = 1'b1;

	// Operation carried from the front part to the back part
	typedef enum logic [3:0] {
		OP_RELU,
		OP_LINEAR,
		OP_SIGMOID,
		OP_TANH,
		OP_SOFTMAX,
		OP_D_RELU,
		OP_D_SIG,
		OP_D_TANH,
		OP_ONE
	} op_t;

	typedef struct packed {
		op_t                     op;
		logic signed [15:0]      value;   // sample, or row maximum for softmax
		logic                    last;
		logic                    cut;
		logic [CNT_W-1:0]        count;
	} cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       dir;
	} cfg_t;

	typedef enum logic [2:0] {
		EX_IDLE,
		EX_NEST,
		EX_RED,
		EX_MUL1,
		EX_MUL2,
		EX_FIX,
		EX_FIN
	} exp_state_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_SIMPLE,
		BK_MUL,
		BK_DERIV,
		BK_EXP_GO,
		BK_EXP_WAIT,
		BK_DIV_GO,
		BK_DIV_WAIT,
		BK_EMIT,
		BK_SM_READ,
		BK_SM_EXP_GO,
		BK_SM_EXP_WAIT,
		BK_SM_NORM_READ,
		BK_SM_DIV_GO,
		BK_SM_DIV_WAIT,
		BK_SM_EMIT
	} back_state_t;

	// Map the configuration to the operation applied to each sample
	function automatic op_t classify(input cfg_t c);
		op_t o;
		o = OP_LINEAR;
		if (!c.dir) begin
			unique case (c.kind)
				KIND_RELU:    o = OP_RELU;
				KIND_SIGMOID: o = OP_SIGMOID;
				KIND_TANH:    o = OP_TANH;
				KIND_SOFTMAX: o = OP_SOFTMAX;
				default:      o = OP_LINEAR;
			endcase
		end else begin
			unique case (c.kind) inside
				KIND_RELU:                  o = OP_D_RELU;
				KIND_SIGMOID, KIND_SOFTMAX: o = OP_D_SIG;
				KIND_TANH:                  o = OP_D_TANH;
				default:                    o = OP_ONE;
			endcase
		end
		return o;
	endfunction

	// Saturate a wide signed value to 16 bits
	function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
		logic signed [15:0] r;
		if (v > 34'sd32767)
			r = 16'sh7FFF;
		else if (v < -34'sd32768)
			r = 16'sh8000;
		else
			r = v[15:0];
		return r;
	endfunction

endpackage

/* rtl/neural_activation_unit.sv */
// Top level of the neural activation unit: configuration registers, front part,
// command queue, row store and back part. Depends on nau_pkg and all nau_* modules.
//
// Usage. Samples (signed Q4.12) enter through a queue-style port: an item is
// taken when push is high and full is low; row_end marks the last sample of a row.
// Results leave the same way: while empty is low the oldest result sits on
// result/last/overflow and is taken when pop is high.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 kind,
// 1 direction); a write also drops a partly loaded softmax row.
// Relu, linear and their derivatives take the simple path of the back sequencer,
// the sigmoid and tanh derivatives a multiply step first. Sigmoid and tanh run
// the series exponential unit and then the bit-serial divider.
// A softmax row of N samples is loaded at one per cycle while full is low,
// then goes through an exponential pass and a normalize pass over its elements.
// New samples are held off (full high) from a row end until the exponential
// pass has read the row store.
// Reset clears the configuration to forward relu, the row state, the queue and
// the output register (empty high). When the receiver stalls, the output
// register holds its result, the back part waits, the queue fills and full rises.
module neural_activation_unit import nau_pkg::*; #(
	parameter int ROW_MAX    = 64,
	parameter int FIFO_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic signed [15:0] sample,
	input  logic               row_end,
	output logic               full,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] result,
	output logic               last,
	output logic               overflow,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [2:0]         cfg_data
);

	localparam int AW = $clog2(ROW_MAX);

	cfg_t          cfg_q;
	logic          cmd_push, cmd_full, cmd_pop, cmd_empty;
	cmd_t          cmd_wdata, cmd_rdata;
	logic          row_we, row_free;
	logic [AW-1:0] row_waddr, row_raddr;
	logic [15:0]   row_wdata, row_rdata;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KIND: cfg_q.kind <= cfg_data;
				CFG_DIR:  cfg_q.dir  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	nau_front #(.ROW_MAX(ROW_MAX)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cfg_clear (cfg_we),
		.push      (push),
		.sample    (sample),
		.row_end   (row_end),
		.full      (full),
		.cmd_push  (cmd_push),
		.cmd_wdata (cmd_wdata),
		.cmd_full  (cmd_full),
		.row_we    (row_we),
		.row_waddr (row_waddr),
		.row_wdata (row_wdata),
		.row_free  (row_free)
	);

	nau_cmd_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(FIFO_DEPTH)) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_wdata),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_rdata),
		.empty  (cmd_empty)
	);

	nau_ram #(.WIDTH(16), .DEPTH(ROW_MAX)) u_row_store (
		.clk   (clk),
		.we    (row_we),
		.waddr (row_waddr),
		.wdata (row_wdata),
		.raddr (row_raddr),
		.rdata (row_rdata)
	);

	nau_back #(.ROW_MAX(ROW_MAX)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd_rdata (cmd_rdata),
		.cmd_pop   (cmd_pop),
		.row_raddr (row_raddr),
		.row_rdata (row_rdata),
		.row_free  (row_free),
		.pop       (pop),
		.empty     (empty),
		.result    (result),
		.last      (last),
		.overflow  (overflow)
	);

endmodule

/* rtl/nau_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module nau_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/nau_cmd_fifo.sv */
// Small command queue between the front and back parts of the activation unit.
// Generic over width and depth; no package dependencies.
module nau_cmd_fifo #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

/* rtl/nau_exp.sv */
// Iterative exponential unit: e^(-d / 2^FRAC_BITS) in Q30 and in Q.FRAC_BITS.
// Range reduction by ln2, then a series up to the 16th-power term, computed iteratively.
// Depends on nau_pkg.
module nau_exp import nau_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [16:0] d,
	output logic        done,
	output logic [30:0] e_q30,
	output logic [12:0] e_fx
);

	// Truncated reciprocals of the series divisors 1 to 16
	localparam logic [31:0] RECIP_K [16] = '{
		32'hFFFF_FFFF / 32'd1,  32'hFFFF_FFFF / 32'd2,  32'hFFFF_FFFF / 32'd3,
		32'hFFFF_FFFF / 32'd4,  32'hFFFF_FFFF / 32'd5,  32'hFFFF_FFFF / 32'd6,
		32'hFFFF_FFFF / 32'd7,  32'hFFFF_FFFF / 32'd8,  32'hFFFF_FFFF / 32'd9,
		32'hFFFF_FFFF / 32'd10, 32'hFFFF_FFFF / 32'd11, 32'hFFFF_FFFF / 32'd12,
		32'hFFFF_FFFF / 32'd13, 32'hFFFF_FFFF / 32'd14, 32'hFFFF_FFFF / 32'd15,
		32'hFFFF_FFFF / 32'd16
	};

	exp_state_t         state_q, state_d;
	logic [16:0]        d_q;
	logic [4:0]         n_q;
	logic [29:0]        r_q;
	logic [30:0]        term_q;
	logic signed [32:0] sum_q;
	logic [3:0]         km1_q;
	logic [60:0]        prod_q;
	logic [29:0]        p_q;
	logic [61:0]        qe_q;
	logic               done_q;
	logic [30:0]        e_q30_q;
	logic [12:0]        e_fx_q;

	logic [37:0] nprod;
	logic [34:0] big, sub, r0;
	logic [4:0]  kval;
	logic [29:0] qe;
	logic [30:0] kprod, rem;
	logic [29:0] qcor;
	logic [30:0] clamp;
	logic [30:0] vshift;
	logic [31:0] vround;

	// Range reduction: n = floor(d * 2^Q_SHIFT / ln2), estimated then corrected
	assign nprod = 38'(d_q) * 38'(LN2_RECIP[20:0]);
	assign big   = 35'(d_q) << Q_SHIFT;
	assign sub   = 35'(n_q) * 35'(LN2_Q30);
	assign r0    = big - sub;

	// Division of the series term by k through its reciprocal plus one correction
	assign kval  = 5'(km1_q) + 5'd1;
	assign qe    = qe_q[61:32];
	assign kprod = 31'(qe) * 31'(kval);
	assign rem   = 31'(p_q) - kprod;
	assign qcor  = (rem >= 31'(kval)) ? qe + 30'd1 : qe;

	// Final clamp, scale by 2^-n and rounding to the output format
	always_comb begin
		if (sum_q < 0)
			clamp = '0;
		else if (sum_q > $signed(33'(Q30_ONE)))
			clamp = 31'(Q30_ONE);
		else
			clamp = sum_q[30:0];
	end
	assign vshift = clamp >> n_q;
	assign vround = 32'(vshift) + (32'd1 << (Q_SHIFT - 1));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			EX_IDLE: if (start) state_d = EX_NEST;
			EX_NEST: state_d = EX_RED;
			EX_RED:  state_d = EX_MUL1;
			EX_MUL1: state_d = EX_MUL2;
			EX_MUL2: state_d = EX_FIX;
			EX_FIX:  state_d = (km1_q == 4'd15) ? EX_FIN : EX_MUL1;
			EX_FIN:  state_d = EX_IDLE;
			default: state_d = EX_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EX_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == EX_FIN);
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			EX_IDLE: begin
				if (start) d_q <= d;
			end
			EX_NEST: n_q <= nprod[36:32];
			EX_RED: begin
				if (r0 >= 35'(LN2_Q30)) begin
					r_q <= 30'(r0 - 35'(LN2_Q30));
					n_q <= n_q + 5'd1;
				end else begin
					r_q <= r0[29:0];
				end
				term_q <= Q30_ONE[30:0];
				sum_q  <= $signed(33'(Q30_ONE));
				km1_q  <= '0;
			end
			EX_MUL1: prod_q <= 61'(term_q) * 61'(r_q);
			EX_MUL2: begin
				p_q  <= prod_q[59:30];
				qe_q <= 62'(prod_q[59:30]) * 62'(RECIP_K[km1_q]);
			end
			EX_FIX: begin
				term_q <= 31'(qcor);
				// odd k subtracts, even k adds
				if (!km1_q[0])
					sum_q <= sum_q - $signed(33'(qcor));
				else
					sum_q <= sum_q + $signed(33'(qcor));
				km1_q <= km1_q + 4'd1;
			end
			EX_FIN: begin
				e_q30_q <= vshift;
				e_fx_q  <= 13'(vround >> Q_SHIFT);
			end
			default: ;
		endcase
	end

	assign done  = done_q;
	assign e_q30 = e_q30_q;
	assign e_fx  = e_fx_q;

endmodule

/* rtl/nau_div.sv */
// Restoring divider, one quotient bit per cycle, 31 quotient bits.
// The caller keeps num / 2^31 below den. Depends on nothing.
module nau_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [60:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [30:0] quo
);

	logic        busy_q, done_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q, den_q;
	logic [30:0] low_q, quo_q;
	logic [32:0] trial;
	logic        fits;

	assign trial = {rem_q, low_q[30]};
	assign fits  = (trial >= 33'(den_q));

	// Iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd30;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift and subtract
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= 32'(num[60:31]);
			low_q <= num[30:0];
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? 32'(trial - 33'(den_q)) : trial[31:0];
			low_q <= {low_q[29:0], 1'b0};
			quo_q <= {quo_q[29:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

/* rtl/nau_front.sv */
// Front part of the activation unit: accepts samples, classifies them, loads
// softmax rows into the row store and queues commands for the back part.
// Depends on nau_pkg.
module nau_front import nau_pkg::*; #(
	parameter int ROW_MAX = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfg_t                       cfg,
	input  logic                       cfg_clear,
	input  logic                       push,
	input  logic signed [15:0]         sample,
	input  logic                       row_end,
	output logic                       full,
	output logic                       cmd_push,
	output cmd_t                       cmd_wdata,
	input  logic                       cmd_full,
	output logic                       row_we,
	output logic [$clog2(ROW_MAX)-1:0] row_waddr,
	output logic [15:0]                row_wdata,
	input  logic                       row_free
);

	localparam int AW = $clog2(ROW_MAX);
	localparam int CW = $clog2(ROW_MAX + 1);

	logic [CW-1:0]      row_cnt_q;
	logic signed [15:0] row_max_q;
	logic               cut_q;
	logic               row_busy_q;

	op_t                op;
	logic               accept, is_sm, cnt_ok;
	logic [CW-1:0]      cnt_new;
	logic signed [15:0] max_new;
	logic               cut_new;

	assign op     = classify(cfg);
	assign is_sm  = (op == OP_SOFTMAX);
	assign full   = cmd_full || row_busy_q;
	assign accept = push && !full;

	// Row bookkeeping for a softmax sample
	assign cnt_ok  = (row_cnt_q < CW'(ROW_MAX));
	assign cnt_new = cnt_ok ? row_cnt_q + 1'b1 : row_cnt_q;
	assign max_new = (cnt_ok && (row_cnt_q == '0 || sample > row_max_q)) ? sample : row_max_q;
	assign cut_new = cut_q || !cnt_ok;

	assign row_we    = accept && is_sm && cnt_ok;
	assign row_waddr = row_cnt_q[AW-1:0];
	assign row_wdata = sample;

	// Command toward the back part
	always_comb begin
		cmd_push        = accept && (!is_sm || row_end);
		cmd_wdata.op    = op;
		cmd_wdata.value = is_sm ? max_new : sample;
		cmd_wdata.last  = row_end;
		cmd_wdata.cut   = is_sm && cut_new;
		cmd_wdata.count = CNT_W'(cnt_new);
	end

	// Row state: cleared by a register write and at the end of each row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cnt_q  <= '0;
			row_max_q  <= '0;
			cut_q      <= 1'b0;
			row_busy_q <= 1'b0;
		end else begin
			if (cfg_clear) begin
				row_cnt_q <= '0;
				row_max_q <= '0;
				cut_q     <= 1'b0;
			end else if (accept && is_sm) begin
				if (row_end) begin
					row_cnt_q <= '0;
					row_max_q <= '0;
					cut_q     <= 1'b0;
				end else begin
					row_cnt_q <= cnt_new;
					row_max_q <= max_new;
					cut_q     <= cut_new;
				end
			end
			// hold off new samples until the back part has read the row store
			if (accept && is_sm && row_end)
				row_busy_q <= 1'b1;
			else if (row_free)
				row_busy_q <= 1'b0;
		end
	end

endmodule

/* rtl/nau_back.sv */
// Back part of the activation unit: executes queued commands with the shared
// exponential unit and divider, runs softmax passes and holds the output register.
// Depends on nau_pkg, nau_exp, nau_div and nau_ram.
module nau_back import nau_pkg::*; #(
	parameter int ROW_MAX = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_empty,
	input  cmd_t                       cmd_rdata,
	output logic                       cmd_pop,
	output logic [$clog2(ROW_MAX)-1:0] row_raddr,
	input  logic [15:0]                row_rdata,
	output logic                       row_free,
	input  logic                       pop,
	output logic                       empty,
	output logic signed [15:0]         result,
	output logic                       last,
	output logic                       overflow
);

	localparam int AW = $clog2(ROW_MAX);
	localparam int CW = $clog2(ROW_MAX + 1);

	back_state_t        state_q, state_d;
	op_t                op_q;
	logic signed [15:0] x_q;
	logic               clast_q, cut_q;
	logic [CW-1:0]      cnt_q, i_q;
	logic [19:0]        total_q;
	logic [30:0]        e30_q;
	logic signed [33:0] prod_q;
	logic signed [15:0] res_q;
	logic               rlast_q, rovf_q;
	logic               out_valid_q;
	logic signed [15:0] out_result_q;
	logic               out_last_q, out_ovf_q;

	logic               exp_start, exp_done;
	logic [16:0]        exp_d;
	logic [30:0]        exp_q30;
	logic [12:0]        exp_fx;
	logic               div_start, div_done;
	logic [60:0]        div_num;
	logic [31:0]        div_den;
	logic [30:0]        div_quo;
	logic               exp_we;
	logic [15:0]        exp_rdata;
	logic               out_free, out_load, pass_end, row_last;

	logic [16:0]        ax;
	logic signed [16:0] x17, mb;
	logic signed [33:0] rnd;
	logic signed [15:0] simple_res, deriv_res, sig_res;
	logic [31:0]        sig_den;
	logic [31:0]        tround;
	logic [12:0]        tfx;
	logic [20:0]        tsum;

	nau_exp u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (exp_start),
		.d      (exp_d),
		.done   (exp_done),
		.e_q30  (exp_q30),
		.e_fx   (exp_fx)
	);

	nau_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	nau_ram #(.WIDTH(16), .DEPTH(ROW_MAX)) u_exp_store (
		.clk   (clk),
		.we    (exp_we),
		.waddr (i_q[AW-1:0]),
		.wdata (16'(exp_fx)),
		.raddr (i_q[AW-1:0]),
		.rdata (exp_rdata)
	);

	assign row_raddr = i_q[AW-1:0];
	assign out_free  = !out_valid_q || pop;
	assign pass_end  = (i_q + 1'b1 == cnt_q);
	assign row_last  = pass_end;

	// Elementwise arithmetic
	assign x17 = 17'(x_q);
	assign ax  = x_q[15] ? 17'(-x17) : 17'(x17);
	assign mb  = (op_q == OP_D_SIG) ? 17'(FX_ONE) - x17 : x17;
	assign rnd = (prod_q + 34'sd2048) >>> FRAC_BITS;

	always_comb begin
		case (op_q)
			OP_RELU:   simple_res = (x_q > 16'sd0) ? x_q : 16'sd0;
			OP_D_RELU: simple_res = (x_q > 16'sd0) ? FX_ONE : 16'sd0;
			OP_ONE:    simple_res = FX_ONE;
			default:   simple_res = x_q;
		endcase
	end

	assign deriv_res = (op_q == OP_D_TANH) ? sat16(34'(FX_ONE) - rnd) : sat16(rnd);

	// Sigmoid and tanh: ratio of Q30 values, rounded to the output format
	assign sig_den = Q30_ONE + 32'(e30_q);
	assign tround  = 32'(div_quo) + (32'd1 << (Q_SHIFT - 1));
	assign tfx     = 13'(tround >> Q_SHIFT);
	assign sig_res = (op_q == OP_TANH && x_q[15]) ? -$signed(16'(tfx)) : $signed(16'(tfx));

	// Saturating row total of the exponentials
	assign tsum = 21'(total_q) + 21'(exp_fx);

	// Operands of the shared units
	always_comb begin
		if (state_q == BK_SM_EXP_GO)
			exp_d = 17'(x17 - 17'($signed(row_rdata)));
		else if (op_q == OP_TANH)
			exp_d = 17'(ax << 1);
		else
			exp_d = ax;
	end

	always_comb begin
		if (state_q == BK_SM_DIV_GO) begin
			div_num = (61'(exp_rdata) << FRAC_BITS) + 61'(total_q >> 1);
			div_den = 32'(total_q);
		end else begin
			if (op_q == OP_TANH)
				div_num = (61'(Q30_ONE - 32'(e30_q)) << 30) + 61'(sig_den >> 1);
			else if (x_q[15])
				div_num = (61'(e30_q) << 30) + 61'(sig_den >> 1);
			else
				div_num = (61'(Q30_ONE) << 30) + 61'(sig_den >> 1);
			div_den = sig_den;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!cmd_empty) begin
					unique case (cmd_rdata.op) inside
						OP_SIGMOID, OP_TANH: state_d = BK_EXP_GO;
						OP_SOFTMAX:          state_d = BK_SM_READ;
						OP_D_SIG, OP_D_TANH: state_d = BK_MUL;
						default:             state_d = BK_SIMPLE;
					endcase
				end
			end
			BK_SIMPLE:       state_d = BK_EMIT;
			BK_MUL:          state_d = BK_DERIV;
			BK_DERIV:        state_d = BK_EMIT;
			BK_EXP_GO:       state_d = BK_EXP_WAIT;
			BK_EXP_WAIT:     if (exp_done) state_d = BK_DIV_GO;
			BK_DIV_GO:       state_d = BK_DIV_WAIT;
			BK_DIV_WAIT:     if (div_done) state_d = BK_EMIT;
			BK_EMIT:         if (out_free) state_d = BK_IDLE;
			BK_SM_READ:      state_d = BK_SM_EXP_GO;
			BK_SM_EXP_GO:    state_d = BK_SM_EXP_WAIT;
			BK_SM_EXP_WAIT: begin
				if (exp_done) state_d = pass_end ? BK_SM_NORM_READ : BK_SM_READ;
			end
			BK_SM_NORM_READ: state_d = BK_SM_DIV_GO;
			BK_SM_DIV_GO:    state_d = BK_SM_DIV_WAIT;
			BK_SM_DIV_WAIT:  if (div_done) state_d = BK_SM_EMIT;
			BK_SM_EMIT: begin
				if (out_free) state_d = rlast_q ? BK_IDLE : BK_SM_NORM_READ;
			end
			default:         state_d = BK_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		cmd_pop   = 1'b0;
		exp_start = 1'b0;
		div_start = 1'b0;
		exp_we    = 1'b0;
		row_free  = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			BK_IDLE:        cmd_pop = !cmd_empty;
			BK_EXP_GO:      exp_start = 1'b1;
			BK_SM_EXP_GO:   exp_start = 1'b1;
			BK_DIV_GO:      div_start = 1'b1;
			BK_SM_DIV_GO:   div_start = 1'b1;
			BK_SM_EXP_WAIT: begin
				exp_we   = exp_done;
				row_free = exp_done && pass_end;
			end
			BK_EMIT:        out_load = out_free;
			BK_SM_EMIT:     out_load = out_free;
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			i_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd_pop)
				i_q <= '0;
			else if (state_q == BK_SM_EXP_WAIT && exp_done)
				i_q <= pass_end ? '0 : i_q + 1'b1;
			else if (state_q == BK_SM_EMIT && out_free)
				i_q <= i_q + 1'b1;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

	// Command and datapath registers
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			op_q    <= cmd_rdata.op;
			x_q     <= cmd_rdata.value;
			clast_q <= cmd_rdata.last;
			cut_q   <= cmd_rdata.cut;
			cnt_q   <= cmd_rdata.count[CW-1:0];
			total_q <= '0;
		end
		case (state_q)
			BK_SIMPLE: begin
				res_q   <= simple_res;
				rlast_q <= clast_q;
				rovf_q  <= 1'b0;
			end
			BK_MUL:    prod_q <= x17 * mb;
			BK_DERIV: begin
				res_q   <= deriv_res;
				rlast_q <= clast_q;
				rovf_q  <= 1'b0;
			end
			BK_EXP_WAIT: begin
				if (exp_done) e30_q <= exp_q30;
			end
			BK_DIV_WAIT: begin
				if (div_done) begin
					res_q   <= sig_res;
					rlast_q <= clast_q;
					rovf_q  <= 1'b0;
				end
			end
			BK_SM_EXP_WAIT: begin
				if (exp_done) total_q <= tsum[20] ? 20'hFFFFF : tsum[19:0];
			end
			BK_SM_DIV_WAIT: begin
				if (div_done) begin
					res_q   <= sat16(34'(div_quo));
					rlast_q <= row_last;
					rovf_q  <= cut_q;
				end
			end
			default: ;
		endcase
		if (out_load) begin
			out_result_q <= res_q;
			out_last_q   <= rlast_q;
			out_ovf_q    <= rovf_q;
		end
	end

	assign empty    = !out_valid_q;
	assign result   = out_result_q;
	assign last     = out_last_q;
	assign overflow = out_ovf_q;

endmodule
